>>> rtl/assert_macros.svh
// Assertion helpers shared by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// In the cycle after trig, expect res.
`define ASSERT_NEXT(name, clk, rst_n, trig, res, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) else $error(msg);

`endif

>>> rtl/tclr_pkg.sv
package tclr_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_TERM_EOL,
    ST_TERM_CUR,
    ST_READ
  } state_e;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] TERMINATOR   = 8'd0;

endpackage

>>> rtl/tclr_store.sv
module tclr_store #(
  parameter int DEPTH = 330,
  parameter int AW    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/text_console_line_ring_core.sv
// Scrolling text console: a ring of ROWS lines, each COLS characters plus a
// terminator column, held in one character memory.
// Input channel (in_valid_i/in_ready_o) takes an operation with a character,
// a visible row and a column. Output channel (out_valid_o/out_ready_i)
// returns exactly one result per operation: the read character and row flag
// (zero unless a read) and the cursor, used line count and top line after
// the operation.
// Clear and no-op finish in ST_IDLE; a read goes on to ST_READ for the
// registered memory read, a put to ST_TERM_CUR and, when the line ends,
// first to ST_TERM_EOL to write the terminator column: the single write
// port of the character memory takes a put's two or three cells in turn.
// No new item is taken outside ST_IDLE. After reset a wipe pass writes zero
// to all ROWS*(COLS+1) cells; in_ready_o stays low until it finishes.
// The result sits in an output register. A new item is accepted only when
// that register is empty or is being taken in the same cycle, so a stalled
// receiver holds in_ready_o low for as long as a result waits.
module text_console_line_ring_core #(
  parameter int ROWS = 10,
  parameter int COLS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic [3:0] view_row_i,
  input  logic [5:0] view_col_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_char_o,
  output logic       row_in_use_o,
  output logic [3:0] cursor_row_o,
  output logic [4:0] cursor_col_o,
  output logic [3:0] lines_used_o,
  output logic [3:0] top_line_o
);

  `include "assert_macros.svh"

  localparam int LINE_PITCH = COLS + 1;
  localparam int DEPTH      = ROWS * LINE_PITCH;
  localparam int AW         = $clog2(DEPTH);
  localparam int LW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLS);
  localparam int CPW        = $clog2(COLS + 1);
  localparam int UW         = $clog2(ROWS + 1);

  function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] line,
                                              input logic [CPW-1:0] col);
    cell_addr = AW'(line) * AW'(LINE_PITCH) + AW'(col);
  endfunction

  tclr_pkg::state_e state_q, state_d;

  logic [LW-1:0] wl_q, wl_d;
  logic [CW-1:0] wc_q, wc_d;
  logic [LW-1:0] fl_q, fl_d;
  logic [UW-1:0] ul_q, ul_d;
  logic [LW-1:0] old_line_q, old_line_d;
  logic [AW-1:0] wipe_q, wipe_d;
  logic          rd_ok_q, rd_ok_d;
  logic          rd_use_q, rd_use_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_use_q, out_use_d;
  logic [3:0]    out_row_q, out_row_d;
  logic [4:0]    out_col_q, out_col_d;
  logic [3:0]    out_used_q, out_used_d;
  logic [3:0]    out_top_q, out_top_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // put datapath
  logic          is_nl;
  logic [CW:0]   wc_inc;
  logic          put_wrap;
  logic [UW-1:0] put_ul;
  logic [LW-1:0] put_wl;
  logic [CW-1:0] put_wc;
  logic [LW-1:0] put_fl;
  logic [7:0]    put_data;

  // read datapath
  logic          rd_in_range;
  logic [LW:0]   phys_sum;
  logic [LW-1:0] phys_line;

  logic            accept;
  tclr_pkg::op_e   op;
  logic            slot_free;

  assign op        = tclr_pkg::op_e'(operation_i);
  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    is_nl    = (char_code_i == tclr_pkg::NEWLINE_CODE);
    put_ul   = (ul_q == '0) ? UW'(1) : ul_q;
    put_data = is_nl ? tclr_pkg::TERMINATOR : char_code_i;
    wc_inc   = (CW + 1)'(wc_q) + (CW + 1)'(1);
    put_wrap = is_nl || (wc_inc >= (CW + 1)'(COLS));
    put_wl   = wl_q;
    put_fl   = fl_q;
    put_wc   = wc_inc[CW-1:0];
    if (put_wrap) begin
      put_wc = '0;
      if (put_ul < UW'(ROWS)) begin
        put_ul = put_ul + UW'(1);
      end else begin
        put_fl = (fl_q == LW'(ROWS - 1)) ? '0 : fl_q + LW'(1);
      end
      put_wl = (wl_q == LW'(ROWS - 1)) ? '0 : wl_q + LW'(1);
    end
  end

  always_comb begin
    rd_in_range = (int'(view_row_i) < ROWS) && (int'(view_col_i) <= COLS);
    phys_sum    = (LW + 1)'(fl_q) + (LW + 1)'(LW'(view_row_i));
    if (phys_sum >= (LW + 1)'(ROWS)) begin
      phys_sum = phys_sum - (LW + 1)'(ROWS);
    end
    phys_line = phys_sum[LW-1:0];
    mem_raddr = cell_addr(phys_line, CPW'(view_col_i));
  end

  always_comb begin
    state_d     = state_q;
    wl_d        = wl_q;
    wc_d        = wc_q;
    fl_d        = fl_q;
    ul_d        = ul_q;
    old_line_d  = old_line_q;
    wipe_d      = wipe_q;
    rd_ok_d     = rd_ok_q;
    rd_use_d    = rd_use_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cell_addr(wl_q, CPW'(wc_q));
    mem_wdata   = tclr_pkg::TERMINATOR;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_use_d   = out_use_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_used_d  = out_used_q;
    out_top_d   = out_top_q;

    unique case (state_q)
      tclr_pkg::ST_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = wipe_q;
        wipe_d    = wipe_q + AW'(1);
        if (wipe_q == AW'(DEPTH - 1)) begin
          state_d = tclr_pkg::ST_IDLE;
        end
      end
      tclr_pkg::ST_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          out_char_d = '0;
          out_use_d  = 1'b0;
          unique case (op)
            tclr_pkg::OP_PUT: begin
              mem_we     = 1'b1;
              mem_wdata  = put_data;
              old_line_d = wl_q;
              wl_d       = put_wl;
              wc_d       = put_wc;
              fl_d       = put_fl;
              ul_d       = put_ul;
              state_d    = put_wrap ? tclr_pkg::ST_TERM_EOL : tclr_pkg::ST_TERM_CUR;
            end
            tclr_pkg::OP_CLEAR: begin
              wl_d = '0;
              wc_d = '0;
              fl_d = '0;
              ul_d = '0;
            end
            tclr_pkg::OP_READ: begin
              rd_ok_d  = rd_in_range;
              rd_use_d = rd_in_range && (int'(view_row_i) < int'(ul_q));
              state_d  = tclr_pkg::ST_READ;
            end
            default: begin
            end
          endcase
          // a read publishes its result once the memory data is back
          if (op != tclr_pkg::OP_READ) begin
            out_valid_d = 1'b1;
            out_row_d   = 4'(wl_d);
            out_col_d   = 5'(wc_d);
            out_used_d  = 4'(ul_d);
            out_top_d   = 4'(fl_d);
          end
        end
      end
      tclr_pkg::ST_TERM_EOL: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(old_line_q, CPW'(COLS));
        state_d   = tclr_pkg::ST_TERM_CUR;
      end
      tclr_pkg::ST_TERM_CUR: begin
        mem_we  = 1'b1;
        state_d = tclr_pkg::ST_IDLE;
      end
      tclr_pkg::ST_READ: begin
        out_valid_d = 1'b1;
        out_char_d  = rd_ok_q ? mem_rdata : 8'd0;
        out_use_d   = rd_use_q;
        out_row_d   = 4'(wl_q);
        out_col_d   = 5'(wc_q);
        out_used_d  = 4'(ul_q);
        out_top_d   = 4'(fl_q);
        state_d     = tclr_pkg::ST_IDLE;
      end
      default: begin
        state_d = tclr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tclr_pkg::ST_WIPE;
      wl_q        <= '0;
      wc_q        <= '0;
      fl_q        <= '0;
      ul_q        <= '0;
      wipe_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      wc_q        <= wc_d;
      fl_q        <= fl_d;
      ul_q        <= ul_d;
      wipe_q      <= wipe_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_line_q <= old_line_d;
    rd_ok_q    <= rd_ok_d;
    rd_use_q   <= rd_use_d;
    out_char_q <= out_char_d;
    out_use_q  <= out_use_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_used_q <= out_used_d;
    out_top_q  <= out_top_d;
  end

  tclr_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_char_o  = out_char_q;
  assign row_in_use_o = out_use_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign lines_used_o = out_used_q;
  assign top_line_o   = out_top_q;

  `ASSERT_HOLDS(a_cursor_range, clk_i, rst_ni,
    (int'(wl_q) < ROWS) && (int'(wc_q) < COLS) && (int'(ul_q) <= ROWS),
    "cursor or line count out of range")
  `ASSERT_HOLDS(a_top_idle_when_empty, clk_i, rst_ni,
    (ul_q != '0) || (fl_q == '0), "top line moved with no lines in use")
  `ASSERT_NEXT(a_put_writes_on, clk_i, rst_ni, accept && (op == tclr_pkg::OP_PUT),
    (state_q == tclr_pkg::ST_TERM_EOL) || (state_q == tclr_pkg::ST_TERM_CUR),
    "put did not go on to write its terminator")
  `ASSERT_NEXT(a_read_slot_free, clk_i, rst_ni, accept && (op == tclr_pkg::OP_READ),
    !out_valid_q, "read data returned while the output register is full")

endmodule

>>> tb/sv/tb_text_console_line_ring_core.sv
module tb_text_console_line_ring_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS         = 10;
  localparam int COLS         = 32;
  localparam int PITCH        = COLS + 1;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 150000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] read_char;
    logic       row_in_use;
    logic [3:0] cursor_row;
    logic [4:0] cursor_col;
    logic [3:0] lines_used;
    logic [3:0] top_line;
  } console_view_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  tclr_pkg::op_e operation_i = tclr_pkg::OP_NOP;
  logic [7:0]    char_code_i = '0;
  logic [3:0]    view_row_i  = '0;
  logic [5:0]    view_col_i  = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [7:0]    read_char_o;
  logic          row_in_use_o;
  logic [3:0]    cursor_row_o;
  logic [4:0]    cursor_col_o;
  logic [3:0]    lines_used_o;
  logic [3:0]    top_line_o;

  // Console shadow: character cells and counters after every accepted transfer
  logic [7:0]    cell_mem [ROWS][PITCH];
  int unsigned   cur_line;
  int unsigned   cur_col;
  int unsigned   top_row;
  int unsigned   rows_shown;
  console_view_t pending_views[$];

  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned op_cnt    = 0;
  int unsigned hold_cnt  = 0;
  bit          steady    = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  text_console_line_ring_core #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .char_code_i (char_code_i),
    .view_row_i  (view_row_i),
    .view_col_i  (view_col_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_char_o (read_char_o),
    .row_in_use_o(row_in_use_o),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o),
    .lines_used_o(lines_used_o),
    .top_line_o  (top_line_o)
  );

  function automatic void console_power_up();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < PITCH; c++) begin
        cell_mem[r][c] = '0;
      end
    end
    cur_line   = 0;
    cur_col    = 0;
    top_row    = 0;
    rows_shown = 0;
  endfunction

  function automatic console_view_t console_apply(tclr_pkg::op_e op, logic [7:0] code,
                                                  logic [3:0] vrow, logic [5:0] vcol);
    console_view_t view;
    int unsigned   phys;
    view = '0;
    case (op)
      tclr_pkg::OP_PUT: begin
        if (rows_shown == 0) rows_shown = 1;
        if (code != tclr_pkg::NEWLINE_CODE) begin
          cell_mem[cur_line][cur_col] = code;
          cur_col++;
        end else begin
          cell_mem[cur_line][cur_col] = tclr_pkg::TERMINATOR;
          cur_col = COLS;
        end
        // Line finished: close it and advance round the ring, scrolling when full
        if (cur_col >= COLS) begin
          cell_mem[cur_line][COLS] = tclr_pkg::TERMINATOR;
          cur_col = 0;
          if (rows_shown < ROWS) rows_shown++;
          else top_row = (top_row + 1) % ROWS;
          cur_line = (cur_line + 1) % ROWS;
        end
        cell_mem[cur_line][cur_col] = tclr_pkg::TERMINATOR;
      end
      tclr_pkg::OP_CLEAR: begin
        cur_line   = 0;
        cur_col    = 0;
        top_row    = 0;
        rows_shown = 0;
      end
      tclr_pkg::OP_READ: begin
        if (vrow < ROWS && vcol <= COLS) begin
          phys            = (top_row + vrow) % ROWS;
          view.read_char  = cell_mem[phys][vcol];
          view.row_in_use = (vrow < rows_shown);
        end
      end
      default: ;
    endcase
    view.cursor_row = cur_line[3:0];
    view.cursor_col = cur_col[4:0];
    view.lines_used = rows_shown[3:0];
    view.top_line   = top_row[3:0];
    return view;
  endfunction

  function automatic string view_str(console_view_t v);
    return $sformatf("char=%02h in_use=%0d row=%0d col=%0d used=%0d top=%0d",
                     v.read_char, v.row_in_use, v.cursor_row, v.cursor_col,
                     v.lines_used, v.top_line);
  endfunction

  // Send one operation; valid stays high across back-to-back transfers
  task automatic send_op(tclr_pkg::op_e op, logic [7:0] code, logic [3:0] vrow,
                         logic [5:0] vcol);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    char_code_i <= code;
    view_row_i  <= vrow;
    view_col_i  <= vcol;
    do @(posedge clk_i); while (!in_ready_o);
    pending_views.push_back(console_apply(op, code, vrow, vcol));
    if (op != tclr_pkg::OP_NOP) op_cnt++;
  endtask

  task automatic put_char(logic [7:0] code);
    send_op(tclr_pkg::OP_PUT, code, 4'($urandom), 6'($urandom));
  endtask

  task automatic read_cell(logic [3:0] vrow, logic [5:0] vcol);
    send_op(tclr_pkg::OP_READ, 8'($urandom), vrow, vcol);
  endtask

  always @(posedge clk_i) begin : check_results
    console_view_t got;
    console_view_t want;
    if (out_valid_o && out_ready_i) begin
      got = '{read_char_o, row_in_use_o, cursor_row_o, cursor_col_o,
              lines_used_o, top_line_o};
      if (pending_views.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("[%0t] unexpected result: %s", $realtime, view_str(got));
      end else begin
        want = pending_views.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] mismatch: expected %s, got %s", $realtime,
                     view_str(want), view_str(got));
        end
      end
      hold_cnt = steady ? 0 : $urandom_range(0, 4);
    end else if (hold_cnt != 0) begin
      hold_cnt--;
    end
    out_ready_i <= (hold_cnt == 0);
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Zero, 0xff and a newline go into line 0, then one character into line 1
  task automatic test_put_extremes();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(tclr_pkg::NEWLINE_CODE);
    put_char(8'h7E);
    read_cell(4'd0, 6'd0);
    read_cell(4'd0, 6'd1);
    read_cell(4'd0, 6'd2);
    read_cell(4'd0, 6'(COLS));
    read_cell(4'd1, 6'd0);
  endtask

  task automatic test_read_bounds();
    read_cell(4'd9, 6'd0);
    read_cell(4'(ROWS), 6'd5);
    read_cell(4'hF, 6'h3F);
    read_cell(4'd0, 6'(COLS + 1));
  endtask

  // Fill every line with newlines and push past the end to force a scroll
  task automatic test_scroll();
    repeat (ROWS) put_char(tclr_pkg::NEWLINE_CODE);
    read_cell(4'd0, 6'd0);
    read_cell(4'(ROWS - 1), 6'd0);
  endtask

  task automatic test_clear_and_nop();
    send_op(tclr_pkg::OP_NOP, 8'hA5, 4'd3, 6'd7);
    send_op(tclr_pkg::OP_CLEAR, 8'h5A, 4'd12, 6'd40);
    read_cell(4'd0, 6'd1);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned kind;
    int unsigned burst;
    logic [7:0]  code;
    target = op_cnt + RANDOM_ITEMS;
    while (op_cnt < target) begin
      steady = ($urandom_range(0, 3) == 0);
      kind   = $urandom_range(0, 99);
      if (kind < 45) begin
        // A line of text; long ones wrap round to the next ring line
        burst = $urandom_range(0, 40);
        repeat (burst) begin
          code = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
          put_char(code);
        end
        if ($urandom_range(0, 2) != 0) put_char(tclr_pkg::NEWLINE_CODE);
      end else if (kind < 80) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          if ($urandom_range(0, 7) == 0) read_cell(4'($urandom), 6'($urandom));
          else read_cell(4'($urandom_range(0, ROWS - 1)), 6'($urandom_range(0, COLS)));
        end
      end else if (kind < 83) begin
        send_op(tclr_pkg::OP_CLEAR, 8'($urandom), 4'($urandom), 6'($urandom));
      end else begin
        burst = $urandom_range(1, 8);
        repeat (burst)
          send_op(tclr_pkg::op_e'($urandom_range(0, 3)), 8'($urandom), 4'($urandom),
                  6'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    console_power_up();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_put_extremes();
    test_read_bounds();
    test_scroll();
    test_clear_and_nop();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> text_console_line_ring_core.f
+incdir+rtl
rtl/tclr_pkg.sv
rtl/tclr_store.sv
rtl/text_console_line_ring_core.sv
tb/sv/tb_text_console_line_ring_core.sv
